[rtl/core/bmp_pixel_stream_to_rgb565_core_defines.svh]
// assertion helpers shared by the core rtl
`ifndef BMP_PIXEL_STREAM_TO_RGB565_CORE_DEFINES_SVH
`define BMP_PIXEL_STREAM_TO_RGB565_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BMP2565_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BMP2565_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bmp2565_pkg.sv]
`default_nettype none

package bmp2565_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_MODE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPRESSION_CODE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_TOP_DOWN    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X         = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y         = 3'd6;
    localparam int CFG_DATA_W = 16;

    // depth codes
    localparam logic [1:0] DEPTH_16BPP = 2'd0;
    localparam logic [1:0] DEPTH_24BPP = 2'd1;
    localparam logic [1:0] DEPTH_32BPP = 2'd2;

    // compression codes
    localparam logic [7:0] COMP_RGB       = 8'd0;
    localparam logic [7:0] COMP_BITFIELDS = 8'd3;

    // status codes
    localparam logic STATUS_PIXEL = 1'b0;
    localparam logic STATUS_UNSUPPORTED = 1'b1;

    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  depth_mode;
        logic [7:0]  compression_code;
        logic        rows_top_down;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
    } cfg_t;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [15:0] pixel_color;
        logic        final_pixel;
        logic        status;
    } pix_t;

    typedef struct packed {
        logic finished;
        logic error;
    } dec_status_t;

endpackage

`default_nettype wire

[rtl/core/bmp2565_byte_if.sv]
`default_nettype none

interface bmp2565_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/bmp2565_pix_if.sv]
`default_nettype none

interface bmp2565_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] pixel_color;
    logic        final_pixel;
    logic        status;

    modport source (
        output valid, output pixel_x, output pixel_y, output pixel_color,
        output final_pixel, output status, input ready
    );
    modport sink (
        input valid, input pixel_x, input pixel_y, input pixel_color,
        input final_pixel, input status, output ready
    );
endinterface

`default_nettype wire

[rtl/core/bmp2565_decode.sv]
`default_nettype none

module bmp2565_decode
    import bmp2565_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        byte_accept,
    input  wire logic [7:0]  data_byte,
    output      logic        res_valid,
    output      pix_t        res,
    output      dec_status_t status
);

    logic [1:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic [23:0] pixel_bytes_reg, pixel_bytes_next;
    logic [15:0] column_count_reg, column_count_next;
    logic [1:0]  pad_bytes_left_reg, pad_bytes_left_next;
    logic [15:0] rows_done_reg, rows_done_next;
    logic        finished_reg, finished_next;
    logic        error_reg, error_next;

    logic [2:0]  bytes_per_pixel;
    logic        comp_bad;
    logic [15:0] width_eff;
    logic [15:0] height_eff;
    logic [15:0] off_y;
    logic [15:0] word16;
    logic [15:0] color;
    logic [1:0]  row_bytes_mod4;
    logic [1:0]  row_padding;
    logic        row_end;
    logic        last_row;
    logic        pixel_done;

    // depth and compression decode
    always_comb
    begin
        case (cfg.depth_mode)
            DEPTH_16BPP:
            begin
                bytes_per_pixel = 3'd2;
                comp_bad = (cfg.compression_code != COMP_RGB)
                        && (cfg.compression_code != COMP_BITFIELDS);
            end
            DEPTH_24BPP:
            begin
                bytes_per_pixel = 3'd3;
                comp_bad = 1'b0;
            end
            default:
            begin
                bytes_per_pixel = 3'd4;
                comp_bad = (cfg.compression_code != COMP_RGB);
            end
        endcase
    end

    // geometry with zero sizes read as one
    assign width_eff  = (cfg.image_width == 16'd0) ? 16'd1 : cfg.image_width;
    assign height_eff = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
    assign off_y = cfg.rows_top_down ? rows_done_reg
                                     : 16'(height_eff - 16'd1 - rows_done_reg);
    assign row_bytes_mod4 = 2'(width_eff[1:0] * bytes_per_pixel[1:0]);
    assign row_padding    = 2'(2'd0 - row_bytes_mod4);
    assign row_end  = ({1'b0, column_count_reg} + 17'd1) >= {1'b0, width_eff};
    assign last_row = ({1'b0, rows_done_reg} + 17'd1) >= {1'b0, height_eff};
    assign pixel_done = ({1'b0, byte_in_pixel_reg} + 3'd1) >= bytes_per_pixel;

    // color conversion on the last byte of a pixel
    assign word16 = {data_byte, pixel_bytes_reg[7:0]};
    always_comb
    begin
        case (cfg.depth_mode)
            DEPTH_16BPP:
            begin
                if (cfg.compression_code == COMP_BITFIELDS)
                    color = word16;
                else
                    color = {word16[14:5], 1'b0, word16[4:0]};
            end
            DEPTH_24BPP:
                color = {data_byte[7:3], pixel_bytes_reg[15:10], pixel_bytes_reg[7:3]};
            default:
                color = {pixel_bytes_reg[23:19], pixel_bytes_reg[15:10],
                         pixel_bytes_reg[7:3]};
        endcase
    end

    // per-byte state update and result
    always_comb
    begin
        byte_in_pixel_next  = byte_in_pixel_reg;
        pixel_bytes_next    = pixel_bytes_reg;
        column_count_next   = column_count_reg;
        pad_bytes_left_next = pad_bytes_left_reg;
        rows_done_next      = rows_done_reg;
        finished_next       = finished_reg;
        error_next          = error_reg;
        res_valid           = 1'b0;
        res                 = '0;
        if (byte_accept && !finished_reg && !error_reg)
        begin
            if (comp_bad)
            begin
                error_next = 1'b1;
                res_valid  = 1'b1;
                res.status = STATUS_UNSUPPORTED;
            end
            else if (pad_bytes_left_reg != 2'd0)
            begin
                pad_bytes_left_next = 2'(pad_bytes_left_reg - 2'd1);
            end
            else if (!pixel_done)
            begin
                case (byte_in_pixel_reg)
                    2'd0:    pixel_bytes_next[7:0]   = data_byte;
                    2'd1:    pixel_bytes_next[15:8]  = data_byte;
                    2'd2:    pixel_bytes_next[23:16] = data_byte;
                    default: pixel_bytes_next        = pixel_bytes_reg;
                endcase
                byte_in_pixel_next = 2'(byte_in_pixel_reg + 2'd1);
            end
            else
            begin
                byte_in_pixel_next = 2'd0;
                pixel_bytes_next   = '0;
                res_valid          = 1'b1;
                res.pixel_x        = 16'(cfg.origin_x + column_count_reg);
                res.pixel_y        = 16'(cfg.origin_y + off_y);
                res.pixel_color    = color;
                res.status         = STATUS_PIXEL;
                if (row_end)
                begin
                    column_count_next   = 16'd0;
                    pad_bytes_left_next = row_padding;
                    rows_done_next      = 16'(rows_done_reg + 16'd1);
                    if (last_row)
                    begin
                        finished_next   = 1'b1;
                        res.final_pixel = 1'b1;
                    end
                end
                else
                begin
                    column_count_next = 16'(column_count_reg + 16'd1);
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_pixel_reg  <= '0;
            pixel_bytes_reg    <= '0;
            column_count_reg   <= '0;
            pad_bytes_left_reg <= '0;
            rows_done_reg      <= '0;
            finished_reg       <= 1'b0;
            error_reg          <= 1'b0;
        end
        else
        begin
            byte_in_pixel_reg  <= byte_in_pixel_next;
            pixel_bytes_reg    <= pixel_bytes_next;
            column_count_reg   <= column_count_next;
            pad_bytes_left_reg <= pad_bytes_left_next;
            rows_done_reg      <= rows_done_next;
            finished_reg       <= finished_next;
            error_reg          <= error_next;
        end
    end

    assign status.finished = finished_reg;
    assign status.error    = error_reg;

endmodule

`default_nettype wire

[rtl/core/bmp_pixel_stream_to_rgb565_core.sv]
// Converts the pixel array of an uncompressed bitmap, one byte per transaction,
// into RGB565 pixels tagged with their screen position.
// byte_in carries data_byte in file order; pix_out carries pixel_x, pixel_y,
// pixel_color, final_pixel and status, one transaction per finished pixel,
// or a single status transaction when the compression does not suit the depth.
// Header facts are loaded beforehand on the write port (cfg_we, cfg_index,
// cfg_data); writes take effect on the next byte.
// A finished pixel is registered in the output register or the skid entry.
// Throughput: one byte per cycle; bytes that complete no pixel (gathering,
// row padding, bytes after the image or after an error) give no transaction.
// The output register plus one skid entry decouple the two channels: byte_in
// stays ready while the skid entry is empty, so a stalled receiver is absorbed
// for one pixel before byte_in.ready drops.
// Reset clears the decode state, the output queue and the registers to their
// defaults (width 1, height 1, 24 bpp, plain RGB, bottom-up, origin 0,0).
// After the last pixel or an error report the block drops bytes until reset.
`default_nettype none

`include "bmp_pixel_stream_to_rgb565_core_defines.svh"

module bmp_pixel_stream_to_rgb565_core
    import bmp2565_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    bmp2565_byte_if.sink                byte_in,
    bmp2565_pix_if.source               pix_out
);

    cfg_t        cfg_reg, cfg_next;
    logic        byte_accept;
    logic        dec_res_valid;
    pix_t        dec_res;
    dec_status_t dec_status;

    logic        out_valid_reg, out_valid_next;
    pix_t        out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    pix_t        skid_data_reg, skid_data_next;
    logic        out_fire;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:      cfg_next.image_width      = cfg_data;
                CFG_IMAGE_HEIGHT:     cfg_next.image_height     = cfg_data;
                CFG_DEPTH_MODE:       cfg_next.depth_mode       = cfg_data[1:0];
                CFG_COMPRESSION_CODE: cfg_next.compression_code = cfg_data[7:0];
                CFG_ROWS_TOP_DOWN:    cfg_next.rows_top_down    = cfg_data[0];
                CFG_ORIGIN_X:         cfg_next.origin_x         = cfg_data;
                CFG_ORIGIN_Y:         cfg_next.origin_y         = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width      <= 16'd1;
            cfg_reg.image_height     <= 16'd1;
            cfg_reg.depth_mode       <= DEPTH_24BPP;
            cfg_reg.compression_code <= COMP_RGB;
            cfg_reg.rows_top_down    <= 1'b0;
            cfg_reg.origin_x         <= 16'd0;
            cfg_reg.origin_y         <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input handshake
    assign byte_in.ready = !skid_valid_reg;
    assign byte_accept   = byte_in.valid && !skid_valid_reg;

    bmp2565_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .byte_accept (byte_accept),
        .data_byte   (byte_in.data_byte),
        .res_valid   (dec_res_valid),
        .res         (dec_res),
        .status      (dec_status)
    );

    // output register and skid entry
    assign out_fire = out_valid_reg && pix_out.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = dec_res_valid;
                out_data_next  = dec_res;
            end
        end
        else if (dec_res_valid)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = dec_res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = dec_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign pix_out.valid       = out_valid_reg;
    assign pix_out.pixel_x     = out_data_reg.pixel_x;
    assign pix_out.pixel_y     = out_data_reg.pixel_y;
    assign pix_out.pixel_color = out_data_reg.pixel_color;
    assign pix_out.final_pixel = out_data_reg.final_pixel;
    assign pix_out.status      = out_data_reg.status;

    // checks
    `BMP2565_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry full while output empty")
    `BMP2565_ASSERT_NEXT(a_stall_fills_skid,
        out_valid_reg && !pix_out.ready && dec_res_valid, skid_valid_reg,
        "stalled result not parked in skid entry")
    `BMP2565_ASSERT_NOW(a_no_result_when_halted,
        dec_status.finished || dec_status.error, !dec_res_valid,
        "result produced after image end or error")
    `BMP2565_ASSERT_NEXT(a_error_sticks, dec_res_valid && dec_res.status,
        dec_status.error, "error result without error state")

endmodule

`default_nettype wire
